[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rvid_pkg.sv]
// ----------------------------------------------------------------------------
// rvid_pkg
// types and constants of the rv32i instruction decoder
// ----------------------------------------------------------------------------
`default_nettype none

package rvid_pkg;

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [1:0] LEN_32BIT  = 2'b11;
    localparam logic [6:0] FUNC7_ALT  = 7'h20;

    localparam logic [4:0] IMM_W_NONE = 5'd0;
    localparam logic [4:0] IMM_W_IS   = 5'd12;
    localparam logic [4:0] IMM_W_B    = 5'd13;
    localparam logic [4:0] IMM_W_U    = 5'd20;
    localparam logic [4:0] IMM_W_J    = 5'd21;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOT32   = 2'd1,
        ST_BAD_OPC = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_R    = 3'd1,
        FMT_I    = 3'd2,
        FMT_S    = 3'd3,
        FMT_B    = 3'd4,
        FMT_U    = 3'd5,
        FMT_J    = 3'd6
    } t_format;

    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_ALU    = 3'd1,
        CLS_LOAD   = 3'd2,
        CLS_STORE  = 3'd3,
        CLS_BRANCH = 3'd4,
        CLS_JUMP   = 3'd5,
        CLS_UPPER  = 3'd6,
        CLS_SYSTEM = 3'd7
    } t_class;

    typedef enum logic [3:0] {
        ALU_NONE  = 4'd0,
        ALU_ADD   = 4'd1,
        ALU_SUB   = 4'd2,
        ALU_SLL   = 4'd3,
        ALU_SLT   = 4'd4,
        ALU_LTU   = 4'd5,
        ALU_XOR   = 4'd6,
        ALU_SRL   = 4'd7,
        ALU_SRA   = 4'd8,
        ALU_OR    = 4'd9,
        ALU_AND   = 4'd10,
        ALU_PASSB = 4'd11
    } t_alu_op;

    typedef struct packed {
        t_status            status;
        t_format            format;
        t_class             instr_class;
        t_alu_op            alu_op;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic [2:0]         func3;
        logic [6:0]         func7;
        logic signed [31:0] immediate;
        logic [4:0]         imm_width;
    } t_dec;

endpackage

`default_nettype wire

[hdl/rvid_in_if.sv]
// ----------------------------------------------------------------------------
// rvid_in_if
// instruction word channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface rvid_in_if;

    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);

endinterface

`default_nettype wire

[hdl/rvid_out_if.sv]
// ----------------------------------------------------------------------------
// rvid_out_if
// decoded instruction channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface rvid_out_if;

    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [2:0]         format;
    logic [2:0]         instr_class;
    logic [3:0]         alu_op;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic [2:0]         func3;
    logic [6:0]         func7;
    logic signed [31:0] immediate;
    logic [4:0]         imm_width;

    modport source (
        output valid, output status, output format, output instr_class,
        output alu_op, output dest_reg, output src1_reg, output src2_reg,
        output func3, output func7, output immediate, output imm_width,
        input ready
    );
    modport sink (
        input valid, input status, input format, input instr_class,
        input alu_op, input dest_reg, input src1_reg, input src2_reg,
        input func3, input func7, input immediate, input imm_width,
        output ready
    );

endinterface

`default_nettype wire

[hdl/rvid_decode.sv]
// ----------------------------------------------------------------------------
// rvid_decode
// combinational decode of one rv32i word into fields, format, class,
// alu operation and sign-extended immediate
// ----------------------------------------------------------------------------
`default_nettype none

module rvid_decode (
    input  wire logic [31:0]  i_word,
    output rvid_pkg::t_dec    o_dec
);

    import rvid_pkg::*;

    function automatic t_alu_op alu_from_funct(
        input logic [2:0] f3,
        input logic [6:0] f7,
        input logic       reg_form
    );
        t_alu_op op;
        unique case (f3)
            3'd0: op = (reg_form && f7 == FUNC7_ALT) ? ALU_SUB : ALU_ADD;
            3'd1: op = ALU_SLL;
            3'd2: op = ALU_SLT;
            3'd3: op = ALU_LTU;
            3'd4: op = ALU_XOR;
            3'd5: op = (f7 == FUNC7_ALT) ? ALU_SRA : ALU_SRL;
            3'd6: op = ALU_OR;
            3'd7: op = ALU_AND;
            default: op = ALU_NONE;
        endcase
        return op;
    endfunction

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;

    assign opc = i_word[6:0];
    assign f3  = i_word[14:12];
    assign f7  = i_word[31:25];

    assign imm_i = {{20{i_word[31]}}, i_word[31:20]};
    assign imm_s = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign imm_b = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                    i_word[11:8], 1'b0};
    assign imm_u = {i_word[31:12], 12'b0};
    assign imm_j = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                    i_word[30:21], 1'b0};

    always_comb begin
        o_dec             = '0;
        o_dec.status      = ST_OK;
        o_dec.format      = FMT_NONE;
        o_dec.instr_class = CLS_NONE;
        o_dec.alu_op      = ALU_NONE;
        o_dec.dest_reg    = i_word[11:7];
        o_dec.src1_reg    = i_word[19:15];
        o_dec.src2_reg    = i_word[24:20];
        o_dec.func3       = f3;
        o_dec.func7       = f7;
        o_dec.immediate   = '0;
        o_dec.imm_width   = IMM_W_NONE;

        if (i_word[1:0] != LEN_32BIT) begin
            o_dec.status = ST_NOT32;
        end else begin
            unique case (opc)
                OPC_OP: begin
                    o_dec.format      = FMT_R;
                    o_dec.instr_class = CLS_ALU;
                    o_dec.alu_op      = alu_from_funct(f3, f7, 1'b1);
                end
                OPC_OPIMM, OPC_LOAD, OPC_JALR, OPC_SYSTEM: begin
                    o_dec.format    = FMT_I;
                    o_dec.imm_width = IMM_W_IS;
                    o_dec.immediate = $signed(imm_i);
                    if (opc == OPC_OPIMM) begin
                        o_dec.instr_class = CLS_ALU;
                        o_dec.alu_op      = alu_from_funct(f3, f7, 1'b0);
                    end else if (opc == OPC_LOAD) begin
                        o_dec.instr_class = CLS_LOAD;
                        o_dec.alu_op      = ALU_ADD;
                    end else if (opc == OPC_JALR) begin
                        o_dec.instr_class = CLS_JUMP;
                        o_dec.alu_op      = ALU_ADD;
                    end else begin
                        o_dec.instr_class = CLS_SYSTEM;
                    end
                end
                OPC_STORE: begin
                    o_dec.format      = FMT_S;
                    o_dec.instr_class = CLS_STORE;
                    o_dec.alu_op      = ALU_ADD;
                    o_dec.imm_width   = IMM_W_IS;
                    o_dec.immediate   = $signed(imm_s);
                end
                OPC_BRANCH: begin
                    o_dec.format      = FMT_B;
                    o_dec.instr_class = CLS_BRANCH;
                    o_dec.imm_width   = IMM_W_B;
                    o_dec.immediate   = $signed(imm_b);
                end
                OPC_LUI, OPC_AUIPC: begin
                    o_dec.format      = FMT_U;
                    o_dec.instr_class = CLS_UPPER;
                    o_dec.imm_width   = IMM_W_U;
                    o_dec.immediate   = $signed(imm_u);
                    o_dec.alu_op      = (opc == OPC_LUI) ? ALU_PASSB : ALU_ADD;
                end
                OPC_JAL: begin
                    o_dec.format      = FMT_J;
                    o_dec.instr_class = CLS_JUMP;
                    o_dec.alu_op      = ALU_ADD;
                    o_dec.imm_width   = IMM_W_J;
                    o_dec.immediate   = $signed(imm_j);
                end
                default: begin
                    o_dec.status = ST_BAD_OPC;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/rv32i_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder
// decodes one rv32i instruction word per transaction into its fields,
// format, class, alu operation and sign-extended immediate
//
//   channel   direction  payload                         handshake
//   i_instr   in         instruction_word[31:0]          valid / ready
//   o_dec     out        status .. imm_width (decoded)   valid / ready
//
// one transaction per clock sustained while o_dec does not stall
// the word is held in an input register, decoded by one level of logic
// and captured in the result register
// a stall on o_dec holds the result; the input register keeps accepting
// until both registers are full
// synchronous active-low reset clears both valid flags only
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rv32i_instruction_decoder (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rvid_in_if.sink    i_instr,
    rvid_out_if.source o_dec
);

    import rvid_pkg::*;

    logic        r_s1_valid;
    logic        n_s1_valid;
    logic [31:0] r_s1_word;
    logic [31:0] n_s1_word;
    logic        r_s2_valid;
    logic        n_s2_valid;
    t_dec        r_s2;
    t_dec        n_s2;
    t_dec        dec;
    logic        s2_ready;
    logic        s1_move;
    logic        in_fire;

    rvid_decode u_decode (
        .i_word (r_s1_word),
        .o_dec  (dec)
    );

    assign s2_ready      = !r_s2_valid || o_dec.ready;
    assign s1_move       = r_s1_valid && s2_ready;
    assign i_instr.ready = !r_s1_valid || s2_ready;
    assign in_fire       = i_instr.valid && i_instr.ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1_word  = r_s1_word;
        n_s2_valid = r_s2_valid;
        n_s2       = r_s2;
        if (s2_ready) begin
            n_s2_valid = r_s1_valid;
            if (r_s1_valid) begin
                n_s2 = dec;
            end
        end
        if (in_fire) begin
            n_s1_valid = 1'b1;
            n_s1_word  = i_instr.instruction_word;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_word <= n_s1_word;
        r_s2      <= n_s2;
    end

    assign o_dec.valid       = r_s2_valid;
    assign o_dec.status      = r_s2.status;
    assign o_dec.format      = r_s2.format;
    assign o_dec.instr_class = r_s2.instr_class;
    assign o_dec.alu_op      = r_s2.alu_op;
    assign o_dec.dest_reg    = r_s2.dest_reg;
    assign o_dec.src1_reg    = r_s2.src1_reg;
    assign o_dec.src2_reg    = r_s2.src2_reg;
    assign o_dec.func3       = r_s2.func3;
    assign o_dec.func7       = r_s2.func7;
    assign o_dec.immediate   = r_s2.immediate;
    assign o_dec.imm_width   = r_s2.imm_width;

    // an accepted word always lands in the input register
    `ASSERT_NEXT(a_in_lands, i_clk, i_rst_n, in_fire, r_s1_valid, "accepted word lost")
    // a waiting word is not overwritten while the result side is stalled
    `ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s2_ready, $stable(r_s1_word), "input register overwritten")
    // rejected words carry no decode
    `ASSERT_SAME(a_bad_clean, i_clk, i_rst_n, r_s2_valid && r_s2.status != ST_OK, r_s2.format == FMT_NONE && r_s2.immediate == 0 && r_s2.imm_width == IMM_W_NONE, "rejected word decoded")
    // register format has no immediate
    `ASSERT_SAME(a_r_noimm, i_clk, i_rst_n, r_s2_valid && r_s2.format == FMT_R, r_s2.immediate == 0 && r_s2.imm_width == IMM_W_NONE, "r format with immediate")
    // branch offsets are even and thirteen bits wide
    `ASSERT_SAME(a_b_even, i_clk, i_rst_n, r_s2_valid && r_s2.format == FMT_B, r_s2.immediate[0] == 1'b0 && r_s2.imm_width == IMM_W_B, "bad branch immediate")

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// testbench of the rv32i instruction decoder: directed and random instruction
// words go through a valid/ready driver, each accepted word is decoded by a
// behavioral model, and every result on the output channel is checked field
// by field against the oldest pending decode, with random stalls on both sides
// ----------------------------------------------------------------------------
module tb;

    import rvid_pkg::*;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam int RANDOM_WORDS = 1050;
    localparam int PHASE_LEN    = 360;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [31:0] word;
        t_dec        dec;
    } t_decode_due;

    logic i_clk;
    logic i_rst_n;

    rvid_in_if  in_ch ();
    rvid_out_if out_ch ();

    rv32i_instruction_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_instr (in_ch),
        .o_dec   (out_ch)
    );

    logic [31:0]  words_to_send[$];
    t_decode_due  decodes_due[$];
    int           words_accepted;
    int           fail_count;
    int           quiet_cycles;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [31:0] encode(input logic [6:0] f7, input logic [4:0] rs2,
                                           input logic [4:0] rs1, input logic [2:0] f3,
                                           input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic t_alu_op alu_for_funct(input logic [2:0] f3, input logic [6:0] f7,
                                              input bit reg_form);
        case (f3)
            F3_ADD:  return (reg_form && f7 == FUNC7_ALT) ? ALU_SUB : ALU_ADD;
            F3_SLL:  return ALU_SLL;
            F3_SLT:  return ALU_SLT;
            F3_SLTU: return ALU_LTU;
            F3_XOR:  return ALU_XOR;
            F3_SR:   return (f7 == FUNC7_ALT) ? ALU_SRA : ALU_SRL;
            F3_OR:   return ALU_OR;
            default: return ALU_AND;
        endcase
    endfunction

    function automatic t_dec decode_word(input logic [31:0] w);
        t_dec       d;
        logic [6:0] opc;
        d = '0;
        opc = w[6:0];
        d.dest_reg = w[11:7];
        d.src1_reg = w[19:15];
        d.src2_reg = w[24:20];
        d.func3    = w[14:12];
        d.func7    = w[31:25];
        if (w[1:0] != LEN_32BIT) begin
            d.status = ST_NOT32;
        end else begin
            case (opc)
                OPC_OP: begin
                    d.format      = FMT_R;
                    d.instr_class = CLS_ALU;
                    d.alu_op      = alu_for_funct(w[14:12], w[31:25], 1'b1);
                end
                OPC_OPIMM, OPC_LOAD, OPC_JALR, OPC_SYSTEM: begin
                    d.format    = FMT_I;
                    d.imm_width = IMM_W_IS;
                    d.immediate = {{20{w[31]}}, w[31:20]};
                    case (opc)
                        OPC_OPIMM: begin
                            d.instr_class = CLS_ALU;
                            d.alu_op      = alu_for_funct(w[14:12], w[31:25], 1'b0);
                        end
                        OPC_LOAD: begin
                            d.instr_class = CLS_LOAD;
                            d.alu_op      = ALU_ADD;
                        end
                        OPC_JALR: begin
                            d.instr_class = CLS_JUMP;
                            d.alu_op      = ALU_ADD;
                        end
                        default: begin
                            d.instr_class = CLS_SYSTEM;
                            d.alu_op      = ALU_NONE;
                        end
                    endcase
                end
                OPC_STORE: begin
                    d.format      = FMT_S;
                    d.instr_class = CLS_STORE;
                    d.alu_op      = ALU_ADD;
                    d.imm_width   = IMM_W_IS;
                    d.immediate   = {{20{w[31]}}, w[31:25], w[11:7]};
                end
                OPC_BRANCH: begin
                    d.format      = FMT_B;
                    d.instr_class = CLS_BRANCH;
                    d.alu_op      = ALU_NONE;
                    d.imm_width   = IMM_W_B;
                    d.immediate   = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                end
                OPC_LUI, OPC_AUIPC: begin
                    d.format      = FMT_U;
                    d.instr_class = CLS_UPPER;
                    d.alu_op      = (opc == OPC_LUI) ? ALU_PASSB : ALU_ADD;
                    d.imm_width   = IMM_W_U;
                    d.immediate   = {w[31:12], 12'h000};
                end
                OPC_JAL: begin
                    d.format      = FMT_J;
                    d.instr_class = CLS_JUMP;
                    d.alu_op      = ALU_ADD;
                    d.imm_width   = IMM_W_J;
                    d.immediate   = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                end
                default: begin
                    d.status = ST_BAD_OPC;
                end
            endcase
        end
        return d;
    endfunction

    function automatic string dec_text(input t_dec d);
        return $sformatf("st=%0d fmt=%0d cls=%0d alu=%0d rd=%0d rs1=%0d rs2=%0d f3=%0d f7=%h imm=%h iw=%0d",
                         d.status, d.format, d.instr_class, d.alu_op, d.dest_reg, d.src1_reg,
                         d.src2_reg, d.func3, d.func7, d.immediate, d.imm_width);
    endfunction

    function automatic string fields_differing(input t_dec e, input t_dec g);
        string s;
        s = "";
        if (g.status      !== e.status)      s = {s, " status"};
        if (g.format      !== e.format)      s = {s, " format"};
        if (g.instr_class !== e.instr_class) s = {s, " instr_class"};
        if (g.alu_op      !== e.alu_op)      s = {s, " alu_op"};
        if (g.dest_reg    !== e.dest_reg)    s = {s, " dest_reg"};
        if (g.src1_reg    !== e.src1_reg)    s = {s, " src1_reg"};
        if (g.src2_reg    !== e.src2_reg)    s = {s, " src2_reg"};
        if (g.func3       !== e.func3)       s = {s, " func3"};
        if (g.func7       !== e.func7)       s = {s, " func7"};
        if (g.immediate   !== e.immediate)   s = {s, " immediate"};
        if (g.imm_width   !== e.imm_width)   s = {s, " imm_width"};
        return s;
    endfunction

    function automatic int sender_idle_pct();
        if (words_accepted < PHASE_LEN) return 9;
        if (words_accepted < 2 * PHASE_LEN) return 86;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (words_accepted < PHASE_LEN) return 86;
        if (words_accepted < 2 * PHASE_LEN) return 9;
        return 0;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                decodes_due.push_back('{in_ch.instruction_word,
                                        decode_word(in_ch.instruction_word)});
                words_accepted <= words_accepted + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    in_ch.valid            <= 1'b1;
                    in_ch.instruction_word <= words_to_send.pop_front();
                end else begin
                    in_ch.valid            <= 1'b0;
                    in_ch.instruction_word <= $urandom;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_decode_due due;
        t_dec        got;
        string       diff;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
            if (out_ch.valid && out_ch.ready) begin
                got.status      = t_status'(out_ch.status);
                got.format      = t_format'(out_ch.format);
                got.instr_class = t_class'(out_ch.instr_class);
                got.alu_op      = t_alu_op'(out_ch.alu_op);
                got.dest_reg    = out_ch.dest_reg;
                got.src1_reg    = out_ch.src1_reg;
                got.src2_reg    = out_ch.src2_reg;
                got.func3       = out_ch.func3;
                got.func7       = out_ch.func7;
                got.immediate   = out_ch.immediate;
                got.imm_width   = out_ch.imm_width;
                if (decodes_due.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("unexpected transaction: %s", dec_text(got));
                    fail_count <= fail_count + 1;
                end else begin
                    due  = decodes_due.pop_front();
                    diff = fields_differing(due.dec, got);
                    if (diff != "") begin
                        if (fail_count < MAX_REPORTS) begin
                            $display("mismatch word %h, fields:%s", due.word, diff);
                            $display("  expected %s", dec_text(due.dec));
                            $display("  actual   %s", dec_text(got));
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("rv32i_instruction_decoder verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [6:0]  base_opcodes[10];
        logic [31:0] w;
        int          kind;
        base_opcodes = '{OPC_LOAD, OPC_OPIMM, OPC_AUIPC, OPC_STORE, OPC_OP,
                         OPC_LUI, OPC_BRANCH, OPC_JALR, OPC_JAL, OPC_SYSTEM};
        i_rst_n                = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.instruction_word = '0;
        out_ch.ready           = 1'b0;
        words_accepted         = 0;
        fail_count             = 0;

        // low bits other than 11, unknown opcode
        words_to_send.push_back(32'h0000_0000);
        words_to_send.push_back(32'hffff_fffd);
        words_to_send.push_back(32'hffff_fffe);
        words_to_send.push_back(32'hffff_ffff);
        // register-register operations, alternate and odd funct7
        words_to_send.push_back(encode(7'h00, 5'd0, 5'd0, F3_ADD, 5'd0, OPC_OP));
        words_to_send.push_back(encode(FUNC7_ALT, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_OP));
        words_to_send.push_back(encode(FUNC7_ALT, 5'd7, 5'd9, F3_SR, 5'd3, OPC_OP));
        words_to_send.push_back(encode(7'h00, 5'd7, 5'd9, F3_SR, 5'd3, OPC_OP));
        words_to_send.push_back(encode(7'h7f, 5'd1, 5'd2, F3_ADD, 5'd3, OPC_OP));
        words_to_send.push_back(encode(7'h7f, 5'd4, 5'd5, F3_SR, 5'd6, OPC_OP));
        words_to_send.push_back(encode(7'h00, 5'd1, 5'd2, F3_SLL, 5'd3, OPC_OP));
        words_to_send.push_back(encode(7'h00, 5'd1, 5'd2, F3_SLT, 5'd3, OPC_OP));
        words_to_send.push_back(encode(7'h00, 5'd1, 5'd2, F3_SLTU, 5'd3, OPC_OP));
        words_to_send.push_back(encode(7'h00, 5'd1, 5'd2, F3_XOR, 5'd3, OPC_OP));
        words_to_send.push_back(encode(7'h00, 5'd1, 5'd2, F3_OR, 5'd3, OPC_OP));
        words_to_send.push_back(encode(7'h00, 5'd1, 5'd2, F3_AND, 5'd3, OPC_OP));
        // immediate forms, alternate funct7 on immediate add and shift
        words_to_send.push_back(encode(FUNC7_ALT, 5'd5, 5'd1, F3_ADD, 5'd2, OPC_OPIMM));
        words_to_send.push_back(encode(FUNC7_ALT, 5'd31, 5'd1, F3_SR, 5'd2, OPC_OPIMM));
        words_to_send.push_back(encode(7'h7f, 5'd31, 5'd0, F3_AND, 5'd31, OPC_LOAD));
        words_to_send.push_back(encode(7'h3f, 5'd0, 5'd31, F3_AND, 5'd31, OPC_STORE));
        words_to_send.push_back(encode(7'h7f, 5'd31, 5'd31, F3_AND, 5'd31, OPC_BRANCH));
        words_to_send.push_back(32'hffff_f000 | 32'(OPC_LUI));
        words_to_send.push_back(32'h8000_0000 | 32'(OPC_AUIPC));
        words_to_send.push_back(32'hffff_f000 | 32'(OPC_JAL));
        words_to_send.push_back(32'h7fff_f000 | 32'(OPC_JAL));
        words_to_send.push_back(encode(7'h40, 5'd0, 5'd7, F3_SLTU, 5'd1, OPC_JALR));
        words_to_send.push_back(32'(OPC_SYSTEM));

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            w    = $urandom;
            kind = $urandom_range(99);
            if (kind < 80) begin
                w[6:0] = base_opcodes[$urandom_range(9)];
                if ((w[6:0] == OPC_OP || w[6:0] == OPC_OPIMM) && $urandom_range(2) != 0)
                    w[31:25] = $urandom_range(1) ? FUNC7_ALT : 7'h00;
            end else if (kind < 90) begin
                w[1:0] = LEN_32BIT;
            end
            words_to_send.push_back(w);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_to_send.size() != 0 || in_ch.valid) @(negedge i_clk);
        while (decodes_due.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && decodes_due.size() == 0) begin
            $display("rv32i_instruction_decoder verification clean");
        end else begin
            $display("rv32i_instruction_decoder verification failed");
        end
        $finish;
    end

endmodule
